// ----- hw/rtl/mks_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, constants and helpers of the matrix keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int ROW_SLOTS = 8;   // row sample ports
    localparam int COL_BITS  = 8;   // bits per row sample
    localparam int ROW_W     = 4;   // key row / column number width
    localparam int PHASE_W   = 2;
    localparam int CFG_W     = 4;   // rows_in_use width
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0]     ROWS_IN_USE_RST = 4'd8;

    localparam logic CMD_SCAN  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Row pattern with exactly one column pulled low, per column.
    localparam logic [COL_BITS-1:0] SINGLE_LOW [ROW_SLOTS] = '{
        8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F
    };

    localparam logic [PHASE_W-1:0] CODE_IDLE            = 2'd0;
    localparam logic [PHASE_W-1:0] CODE_PRESS_CONFIRM   = 2'd1;
    localparam logic [PHASE_W-1:0] CODE_CHECK_RELEASE   = 2'd2;
    localparam logic [PHASE_W-1:0] CODE_RELEASE_CONFIRM = 2'd3;

    typedef logic [ROW_SLOTS-1:0][COL_BITS-1:0] t_row_cols;

    typedef enum logic [3:0] {
        PH_IDLE            = 4'b0001,
        PH_PRESS_CONFIRM   = 4'b0010,
        PH_CHECK_RELEASE   = 4'b0100,
        PH_RELEASE_CONFIRM = 4'b1000
    } t_phase;

    typedef struct packed {
        logic             hit;      // exactly one qualifying row
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] column;
    } t_scan_hit;

    typedef struct packed {
        logic               press_flag;
        logic               release_flag;
        logic [ROW_W-1:0]   key_row;
        logic [ROW_W-1:0]   key_column;
        logic [PHASE_W-1:0] scan_phase;
    } t_result;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase p);
        logic [PHASE_W-1:0] code;
        case (p)
            PH_IDLE:            code = CODE_IDLE;
            PH_PRESS_CONFIRM:   code = CODE_PRESS_CONFIRM;
            PH_CHECK_RELEASE:   code = CODE_CHECK_RELEASE;
            PH_RELEASE_CONFIRM: code = CODE_RELEASE_CONFIRM;
            default:            code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mks_apb_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mks_apb_regs
// APB register file holding the rows_in_use setting.
// ----------------------------------------------------------------------------
module mks_apb_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [mks_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mks_pkg::DATA_W-1:0] pwdata,
    output logic      [mks_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output logic      [mks_pkg::CFG_W-1:0]  o_rows_in_use
);
    import mks_pkg::*;

    logic [CFG_W-1:0]     r_rows_in_use;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_IN_USE_RST;
        end else if (wr_en && reg_idx == REG_ROWS_IN_USE) begin
            r_rows_in_use <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_ROWS_IN_USE) begin
            prdata = {{(DATA_W-CFG_W){1'b0}}, r_rows_in_use};
        end
    end

    assign o_rows_in_use = r_rows_in_use;

endmodule
`default_nettype wire

// ----- hw/rtl/mks_row_detect.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mks_row_detect
// Idle scan: find rows with exactly one low column, reject multi-key scans.
// ----------------------------------------------------------------------------
module mks_row_detect #(
    parameter int NUM_ROWS    = 8,
    parameter int NUM_COLUMNS = 8
) (
    input  wire mks_pkg::t_row_cols             i_rows,
    input  wire logic [mks_pkg::CFG_W-1:0]      i_rows_in_use,
    output mks_pkg::t_scan_hit                  o_hit
);
    import mks_pkg::*;

    localparam logic [COL_BITS-1:0] COL_MASK = COL_BITS'((1 << NUM_COLUMNS) - 1);

    logic [ROW_SLOTS-1:0][ROW_W-1:0] row_col;
    logic [ROW_SLOTS-1:0]            qualify;
    logic                            found;
    logic                            multi;
    logic [ROW_W-1:0]                found_row;
    logic [ROW_W-1:0]                found_col;

    // Column number per row, 0 when the row is not a single-key pattern.
    always_comb begin
        for (int r = 0; r < ROW_SLOTS; r++) begin
            row_col[r] = '0;
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                if ((i_rows[r] & COL_MASK) == (SINGLE_LOW[c] & COL_MASK)) begin
                    row_col[r] = ROW_W'(c + 1);
                end
            end
            qualify[r] = (row_col[r] != '0) && (r < NUM_ROWS)
                         && (ROW_W'(r) < i_rows_in_use);
        end
    end

    // First qualifying row wins; a second one rejects the scan.
    always_comb begin
        found     = 1'b0;
        multi     = 1'b0;
        found_row = '0;
        found_col = '0;
        for (int r = 0; r < ROW_SLOTS; r++) begin
            if (qualify[r]) begin
                if (found) begin
                    multi = 1'b1;
                end else begin
                    found     = 1'b1;
                    found_row = ROW_W'(r + 1);
                    found_col = row_col[r];
                end
            end
        end
        o_hit.hit    = found && !multi;
        o_hit.row    = found_row;
        o_hit.column = found_col;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/mks_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mks_tracker
// Four-phase key tracker with sticky press and release flags.
// ----------------------------------------------------------------------------
module mks_tracker #(
    parameter int NUM_ROWS    = 8,
    parameter int NUM_COLUMNS = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire logic                    i_command,
    input  wire mks_pkg::t_row_cols      i_rows,
    input  wire mks_pkg::t_scan_hit      i_hit,
    output mks_pkg::t_result             o_next
);
    import mks_pkg::*;

    t_phase           r_phase,   n_phase;
    logic [ROW_W-1:0] r_row,     n_row;
    logic [ROW_W-1:0] r_column,  n_column;
    logic             r_pressed, n_pressed;
    logic             r_released, n_released;

    logic key_valid;
    logic key_low;

    // A held key outside the matrix reads as released.
    assign key_valid = (r_row != '0) && (r_row <= ROW_W'(NUM_ROWS))
                       && (r_column != '0) && (r_column <= ROW_W'(NUM_COLUMNS));
    assign key_low = key_valid
                     && !i_rows[3'(r_row - 1'b1)][3'(r_column - 1'b1)];

    always_comb begin
        n_phase    = r_phase;
        n_row      = r_row;
        n_column   = r_column;
        n_pressed  = r_pressed;
        n_released = r_released;
        if (i_command == CMD_CLEAR) begin
            n_phase    = PH_IDLE;
            n_row      = '0;
            n_column   = '0;
            n_pressed  = 1'b0;
            n_released = 1'b0;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_hit.hit) begin
                        n_row    = i_hit.row;
                        n_column = i_hit.column;
                        n_phase  = PH_PRESS_CONFIRM;
                    end else begin
                        n_row    = '0;
                        n_column = '0;
                    end
                end
                PH_PRESS_CONFIRM: begin
                    if (key_low) begin
                        n_pressed = 1'b1;
                        n_phase   = PH_CHECK_RELEASE;
                    end else begin
                        n_row    = '0;
                        n_column = '0;
                        n_phase  = PH_IDLE;
                    end
                end
                PH_CHECK_RELEASE: begin
                    if (!key_low) begin
                        n_phase = PH_RELEASE_CONFIRM;
                    end
                end
                PH_RELEASE_CONFIRM: begin
                    if (key_low) begin
                        n_phase = PH_CHECK_RELEASE;
                    end else begin
                        n_row      = '0;
                        n_column   = '0;
                        n_phase    = PH_IDLE;
                        n_released = 1'b1;
                    end
                end
                default: begin
                    n_row    = '0;
                    n_column = '0;
                    n_phase  = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_row      <= '0;
            r_column   <= '0;
            r_pressed  <= 1'b0;
            r_released <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_row      <= n_row;
            r_column   <= n_column;
            r_pressed  <= n_pressed;
            r_released <= n_released;
        end
    end

    assign o_next.press_flag   = n_pressed;
    assign o_next.release_flag = n_released;
    assign o_next.key_row      = n_row;
    assign o_next.key_column   = n_column;
    assign o_next.scan_phase   = phase_code(n_phase);

endmodule
`default_nettype wire

// ----- hw/rtl/matrix_keypad_scanner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// 8x8 key matrix scanner: single-key detection, press/release confirmation
// over successive scan ticks, sticky event flags, APB row-count setting.
// ----------------------------------------------------------------------------
// Path: an accepted transaction passes input register -> tracker logic ->
//   result register; a stalled status side holds it in the input register.
// Throughput: one transaction per cycle unless the status side stalls;
//   tracker state loads in the same cycle as the result, so ticks chain.
// Reset: synchronous, active low; phase idle, no key held, flags clear,
//   rows_in_use = 8, both pipeline slots empty.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner #(
    parameter int NUM_ROWS    = 8,
    parameter int NUM_COLUMNS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // scan tick channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_command,
    input  wire logic [mks_pkg::COL_BITS-1:0] i_row1_columns,
    input  wire logic [mks_pkg::COL_BITS-1:0] i_row2_columns,
    input  wire logic [mks_pkg::COL_BITS-1:0] i_row3_columns,
    input  wire logic [mks_pkg::COL_BITS-1:0] i_row4_columns,
    input  wire logic [mks_pkg::COL_BITS-1:0] i_row5_columns,
    input  wire logic [mks_pkg::COL_BITS-1:0] i_row6_columns,
    input  wire logic [mks_pkg::COL_BITS-1:0] i_row7_columns,
    input  wire logic [mks_pkg::COL_BITS-1:0] i_row8_columns,
    // status channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_press_flag,
    output logic                             o_release_flag,
    output logic      [mks_pkg::ROW_W-1:0]   o_key_row,
    output logic      [mks_pkg::ROW_W-1:0]   o_key_column,
    output logic      [mks_pkg::PHASE_W-1:0] o_scan_phase,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mks_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mks_pkg::DATA_W-1:0]  pwdata,
    output logic      [mks_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    import mks_pkg::*;

    // Input register: holds one accepted transaction.
    logic      r_in_valid;
    logic      r_command;
    t_row_cols r_rows;

    // Result register.
    logic      r_out_valid;
    t_result   r_result;

    logic             step;
    logic             in_take;
    logic [CFG_W-1:0] rows_in_use;
    t_scan_hit        hit;
    t_result          next_result;

    // Advance the held transaction when the result slot is free or draining.
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    // Stall the input only while a held transaction cannot advance.
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload capture; row 1 lands in slot 0.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command <= i_command;
            r_rows    <= {i_row8_columns, i_row7_columns, i_row6_columns,
                          i_row5_columns, i_row4_columns, i_row3_columns,
                          i_row2_columns, i_row1_columns};
        end
    end

    mks_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_rows_in_use (rows_in_use)
    );

    mks_row_detect #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_detect (
        .i_rows        (r_rows),
        .i_rows_in_use (rows_in_use),
        .o_hit         (hit)
    );

    mks_tracker #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_command (r_command),
        .i_rows    (r_rows),
        .i_hit     (hit),
        .o_next    (next_result)
    );

    // Result slot: load on advance, drop once taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= next_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_press_flag   = r_result.press_flag;
    assign o_release_flag = r_result.release_flag;
    assign o_key_row      = r_result.key_row;
    assign o_key_column   = r_result.key_column;
    assign o_scan_phase   = r_result.scan_phase;

endmodule
`default_nettype wire

// ----- bench/keypad_checker.sv -----
// ----------------------------------------------------------------------------
// keypad_checker
// Watches the scan tick, status and APB channels of the keypad scanner,
// predicts every status transaction and compares it field by field.
// ----------------------------------------------------------------------------
module keypad_checker #(
    parameter int NUM_ROWS    = 8,
    parameter int NUM_COLUMNS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_command,
    input  mks_pkg::t_row_cols          i_rows,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_press_flag,
    input  logic                        i_release_flag,
    input  logic [mks_pkg::ROW_W-1:0]   i_key_row,
    input  logic [mks_pkg::ROW_W-1:0]   i_key_column,
    input  logic [mks_pkg::PHASE_W-1:0] i_scan_phase,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [mks_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [mks_pkg::DATA_W-1:0]  i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mks_pkg::*;

    logic [PHASE_W-1:0] phase_now;
    logic [ROW_W-1:0]   held_row;
    logic [ROW_W-1:0]   held_col;
    logic               press_seen;
    logic               release_seen;
    logic [CFG_W-1:0]   row_count;
    t_result            expected_status[$];
    int                 mismatches = 0;
    int                 backlog = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = backlog;

    // Column number when exactly one column of the row reads low, else 0.
    function automatic logic [ROW_W-1:0] lone_low_column(input logic [COL_BITS-1:0] v);
        logic [ROW_W-1:0] col;
        int               zeros;
        col   = '0;
        zeros = 0;
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            if (!v[c]) begin
                zeros++;
                col = ROW_W'(c + 1);
            end
        end
        return (zeros == 1) ? col : '0;
    endfunction

    // A held key outside the matrix always reads as released.
    function automatic logic key_down(input t_row_cols rows);
        if (held_row < 1 || held_row > NUM_ROWS || held_col < 1 || held_col > NUM_COLUMNS)
            return 1'b0;
        return !rows[int'(held_row) - 1][int'(held_col) - 1];
    endfunction

    function automatic void drop_key();
        held_row  = '0;
        held_col  = '0;
        phase_now = CODE_IDLE;
    endfunction

    function automatic t_result track_keypad(input logic cmd, input t_row_cols rows);
        t_result          res;
        int               limit;
        logic [ROW_W-1:0] hit_row;
        logic [ROW_W-1:0] hit_col;
        logic [ROW_W-1:0] col;
        logic             clash;
        if (cmd == CMD_CLEAR) begin
            drop_key();
            press_seen   = 1'b0;
            release_seen = 1'b0;
        end else begin
            case (phase_now)
                CODE_IDLE: begin
                    limit   = (row_count > NUM_ROWS) ? NUM_ROWS : int'(row_count);
                    hit_row = '0;
                    hit_col = '0;
                    clash   = 1'b0;
                    for (int r = 1; r <= limit; r++) begin
                        col = lone_low_column(rows[r - 1]);
                        if (col != '0 && !clash) begin
                            if (hit_col == '0) begin
                                hit_row = ROW_W'(r);
                                hit_col = col;
                            end else begin
                                clash = 1'b1;
                            end
                        end
                    end
                    if (!clash && hit_col != '0) begin
                        held_row  = hit_row;
                        held_col  = hit_col;
                        phase_now = CODE_PRESS_CONFIRM;
                    end else begin
                        drop_key();
                    end
                end
                CODE_PRESS_CONFIRM: begin
                    if (key_down(rows)) begin
                        press_seen = 1'b1;
                        phase_now  = CODE_CHECK_RELEASE;
                    end else begin
                        drop_key();
                    end
                end
                CODE_CHECK_RELEASE: begin
                    if (!key_down(rows))
                        phase_now = CODE_RELEASE_CONFIRM;
                end
                default: begin
                    if (key_down(rows)) begin
                        phase_now = CODE_CHECK_RELEASE;
                    end else begin
                        drop_key();
                        release_seen = 1'b1;
                    end
                end
            endcase
        end
        res.press_flag   = press_seen;
        res.release_flag = release_seen;
        res.key_row      = held_row;
        res.key_column   = held_col;
        res.scan_phase   = phase_now;
        return res;
    endfunction

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            row_count    = ROWS_IN_USE_RST;
            press_seen   = 1'b0;
            release_seen = 1'b0;
            drop_key();
            expected_status.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[ADDR_W-1:2] == REG_ROWS_IN_USE)
                row_count = i_pwdata[CFG_W-1:0];
            // Retire the oldest expectation before queuing the new one.
            if (i_out_valid && !i_out_stall) begin
                got.press_flag   = i_press_flag;
                got.release_flag = i_release_flag;
                got.key_row      = i_key_row;
                got.key_column   = i_key_column;
                got.scan_phase   = i_scan_phase;
                if (expected_status.size() == 0) begin
                    log_failure($sformatf("status with nothing pending: %p", got));
                end else begin
                    want = expected_status.pop_front();
                    if (got.press_flag !== want.press_flag
                            || got.release_flag !== want.release_flag
                            || got.key_row !== want.key_row
                            || got.key_column !== want.key_column
                            || got.scan_phase !== want.scan_phase)
                        log_failure($sformatf(
                            "status mismatch: expected press=%0d release=%0d row=%0d col=%0d phase=%0d, got press=%0d release=%0d row=%0d col=%0d phase=%0d",
                            want.press_flag, want.release_flag, want.key_row,
                            want.key_column, want.scan_phase,
                            got.press_flag, got.release_flag, got.key_row,
                            got.key_column, got.scan_phase));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_status.push_back(track_keypad(i_command, i_rows));
        end
        backlog = expected_status.size();
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives scan ticks, clear commands and row-count settings into the keypad
// scanner with random gaps and stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mks_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;

    // scan tick channel
    logic               tick_valid = 1'b0;
    logic               tick_stall;
    logic               command = CMD_SCAN;
    t_row_cols          scan_rows = '1;

    // status channel
    logic               status_valid;
    logic               status_stall = 1'b0;
    logic               press_flag;
    logic               release_flag;
    logic [ROW_W-1:0]   key_row;
    logic [ROW_W-1:0]   key_column;
    logic [PHASE_W-1:0] scan_phase;

    // configuration port
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 fail_count;
    int                 pending;

    // Random idling on both sides is allowed while this is set.
    bit                 gaps_on = 1'b1;
    // Rows the scanner examines in idle under the current setting.
    int                 scan_limit = ROW_SLOTS;
    int                 ticks_sent = 0;

    // Row-count settings of the random phases; the last one runs without idling.
    logic [CFG_W-1:0]   row_plan [6] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd8};

    matrix_keypad_scanner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (tick_valid),
        .o_in_stall     (tick_stall),
        .i_command      (command),
        .i_row1_columns (scan_rows[0]),
        .i_row2_columns (scan_rows[1]),
        .i_row3_columns (scan_rows[2]),
        .i_row4_columns (scan_rows[3]),
        .i_row5_columns (scan_rows[4]),
        .i_row6_columns (scan_rows[5]),
        .i_row7_columns (scan_rows[6]),
        .i_row8_columns (scan_rows[7]),
        .o_out_valid    (status_valid),
        .i_out_stall    (status_stall),
        .o_press_flag   (press_flag),
        .o_release_flag (release_flag),
        .o_key_row      (key_row),
        .o_key_column   (key_column),
        .o_scan_phase   (scan_phase),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    keypad_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (tick_valid),
        .i_in_stall     (tick_stall),
        .i_command      (command),
        .i_rows         (scan_rows),
        .i_out_valid    (status_valid),
        .i_out_stall    (status_stall),
        .i_press_flag   (press_flag),
        .i_release_flag (release_flag),
        .i_key_row      (key_row),
        .i_key_column   (key_column),
        .i_scan_phase   (scan_phase),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Status receiver: stall at random while idling is on.
    initial begin
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                status_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                status_stall <= 1'b0;
            end
        end
    end

    // Matrix with every key open except one.
    function automatic t_row_cols one_key(input int r, input int c);
        t_row_cols m;
        m = '1;
        m[r - 1][c - 1] = 1'b0;
        return m;
    endfunction

    // Row reading that never qualifies as a single key: zero or several lows.
    function automatic logic [COL_BITS-1:0] crowded_row();
        logic [COL_BITS-1:0] v;
        v = COL_BITS'($urandom);
        while ($countones(~v) == 1)
            v = COL_BITS'($urandom);
        return v;
    endfunction

    // Random matrix with the tracked key forced down or up; only that key
    // matters once a key is held.
    function automatic t_row_cols key_frame(input int r, input int c, input logic down);
        t_row_cols m;
        m = {$urandom, $urandom};
        m[r - 1][c - 1] = !down;
        return m;
    endfunction

    // Idle scan with exactly one qualifying row among the scanned ones;
    // rows beyond the limit carry anything.
    function automatic t_row_cols detect_frame(input int r, input int c);
        t_row_cols m;
        m = {$urandom, $urandom};
        for (int k = 1; k <= scan_limit; k++)
            if (k != r)
                m[k - 1] = $urandom_range(0, 1) ? '1 : crowded_row();
        m[r - 1] = '1;
        m[r - 1][c - 1] = 1'b0;
        return m;
    endfunction

    // One transaction on the scan tick channel; hold payload until accepted.
    task automatic send_tick(input logic cmd, input t_row_cols rows);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        tick_valid <= 1'b1;
        command    <= cmd;
        scan_rows  <= rows;
        @(posedge i_clk);
        while (tick_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    // Drop valid and wait until every status transaction has come back.
    task automatic settle();
        tick_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Setup and access cycle on the APB port, only with the scanner idle.
    task automatic write_rows_in_use(input logic [CFG_W-1:0] v);
        logic [DATA_W-1:0] data;
        settle();
        data = $urandom;
        data[CFG_W-1:0] = v;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_ROWS_IN_USE, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scan_limit = (v > ROW_SLOTS) ? ROW_SLOTS : int'(v);
    endtask

    // Well-formed press: detect, confirm, hold, release with optional bounce.
    task automatic key_stroke();
        int r;
        int c;
        r = $urandom_range(1, scan_limit);
        c = $urandom_range(1, COL_BITS);
        send_tick(CMD_SCAN, detect_frame(r, c));
        send_tick(CMD_SCAN, key_frame(r, c, 1'b1));
        repeat ($urandom_range(0, 4)) send_tick(CMD_SCAN, key_frame(r, c, 1'b1));
        send_tick(CMD_SCAN, key_frame(r, c, 1'b0));
        while ($urandom_range(0, 3) == 0) begin
            send_tick(CMD_SCAN, key_frame(r, c, 1'b1));
            send_tick(CMD_SCAN, key_frame(r, c, 1'b0));
        end
        send_tick(CMD_SCAN, key_frame(r, c, 1'b0));
    endtask

    initial begin
        t_row_cols twin;
        int        start;
        int        goal;
        int        pick;
        int        r1;
        int        r2;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, full press and release of a corner key
        // with a bounce, unconfirmed press, two keys in different rows,
        // two lows in one row, clear from a busy state.
        send_tick(CMD_CLEAR, '0);
        send_tick(CMD_SCAN, '1);
        send_tick(CMD_SCAN, '0);
        send_tick(CMD_SCAN, one_key(1, 1));
        send_tick(CMD_SCAN, one_key(1, 1));
        send_tick(CMD_SCAN, one_key(1, 1));
        send_tick(CMD_SCAN, '1);
        send_tick(CMD_SCAN, one_key(1, 1));
        send_tick(CMD_SCAN, '1);
        send_tick(CMD_SCAN, '1);
        send_tick(CMD_SCAN, one_key(8, 8));
        send_tick(CMD_SCAN, '1);
        send_tick(CMD_SCAN, one_key(2, 3) & one_key(5, 5));
        twin = one_key(6, 7);
        twin[2] = 8'hF3;
        send_tick(CMD_SCAN, twin);
        send_tick(CMD_SCAN, one_key(6, 7));
        send_tick(CMD_CLEAR, '1);
        send_tick(CMD_CLEAR, '1);

        // Row count zero scans nothing; a count above the matrix scans all rows.
        write_rows_in_use(4'd0);
        send_tick(CMD_SCAN, one_key(1, 4));
        write_rows_in_use(4'd15);
        send_tick(CMD_SCAN, one_key(8, 2));
        send_tick(CMD_SCAN, one_key(8, 2));

        // Random phases, one row-count setting each.
        for (int p = 0; p < 6; p++) begin
            write_rows_in_use(row_plan[p]);
            gaps_on = (p != 5);
            goal    = (scan_limit == 0) ? 40 : 250;
            start   = ticks_sent;
            while (ticks_sent - start < goal) begin
                if (p != 5)
                    gaps_on = ($urandom_range(0, 3) != 0);
                pick = (scan_limit == 0) ? $urandom_range(8, 9) : $urandom_range(0, 9);
                case (pick)
                    6: begin
                        // press that does not survive the confirm tick
                        r1 = $urandom_range(1, scan_limit);
                        r2 = $urandom_range(1, COL_BITS);
                        send_tick(CMD_SCAN, detect_frame(r1, r2));
                        send_tick(CMD_SCAN, key_frame(r1, r2, 1'b0));
                    end
                    7: begin
                        if (scan_limit >= 2) begin
                            // two single-key rows in one scan: reject
                            r1 = $urandom_range(1, scan_limit - 1);
                            r2 = $urandom_range(r1 + 1, scan_limit);
                            twin = detect_frame(r1, $urandom_range(1, COL_BITS));
                            twin[r2 - 1] = '1;
                            twin[r2 - 1][$urandom_range(0, COL_BITS - 1)] = 1'b0;
                            send_tick(CMD_SCAN, twin);
                        end else begin
                            key_stroke();
                        end
                    end
                    8: repeat ($urandom_range(1, 3)) send_tick(CMD_SCAN, {$urandom, $urandom});
                    9: send_tick(CMD_CLEAR, {$urandom, $urandom});
                    default: key_stroke();
                endcase
            end
        end

        // Drain: wait for every status transaction before the verdict.
        tick_valid <= 1'b0;
        gaps_on = 1'b0;
        for (int k = 0; k < 2000 && pending != 0; k++)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- matrix_keypad_scanner.f -----
hw/rtl/mks_pkg.sv
hw/rtl/mks_apb_regs.sv
hw/rtl/mks_row_detect.sv
hw/rtl/mks_tracker.sv
hw/rtl/matrix_keypad_scanner.sv
bench/keypad_checker.sv
bench/testbench.sv
